@@ rtl/tpsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpsp_pkg
// Types and constants shared by the three-pad slider position block.
// ----------------------------------------------------------------------------
package tpsp_pkg;

   localparam int PAD_INDEX_W   = 2;
   localparam int RAW_COUNT_W   = 14;
   localparam int POSITION_W    = 13;
   localparam int LEVEL_W       = 12;
   localparam int SCALE_W       = 10;
   localparam int SHIFT_W       = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 14;

   localparam logic [PAD_INDEX_W-1:0] PAD_2    = 2'd2;
   localparam logic [PAD_INDEX_W-1:0] PAD_NONE = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_PAD0    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_PAD1    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_PAD2    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_SCALE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_SHIFT  = 3'd4;

   localparam logic [RAW_COUNT_W-1:0] OFFSET_PAD0_RESET    = 14'd1153;
   localparam logic [RAW_COUNT_W-1:0] OFFSET_PAD1_RESET    = 14'd1978;
   localparam logic [RAW_COUNT_W-1:0] OFFSET_PAD2_RESET    = 14'd1962;
   localparam logic [SCALE_W-1:0]     POSITION_SCALE_RESET = 10'd100;
   localparam logic [SHIFT_W-1:0]     AVERAGE_SHIFT_RESET  = 4'd4;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN        = -12'sd2000;
   localparam logic signed [LEVEL_W:0]   TOUCH_DOWN_DELTA = 13'sd200;
   localparam logic signed [LEVEL_W:0]   TOUCH_UP_DELTA   = -13'sd600;
   localparam logic signed [LEVEL_W-1:0] IDLE_AVERAGE     = -12'sd650;
   localparam logic [POSITION_W-1:0]     POSITION_MAX     = 13'd8000;

   // |num| * scale stays below 2^21, |den| below 2^12
   localparam int DIVIDEND_W  = 21;
   localparam int DIVISOR_W   = 12;
   localparam int DIV_STEPS   = (DIVIDEND_W + 1) / 2;
   localparam int DIV_SHIFT_W = 2 * DIV_STEPS;
   localparam int DIV_COUNT_W = $clog2(DIV_STEPS + 1);

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } tpsp_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } tpsp_div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/tpsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpsp_if
// Valid/ready channels for acquisition beats and slider result beats.
// ----------------------------------------------------------------------------
interface tpsp_req_if;
   logic                            valid;
   logic                            ready;
   logic [tpsp_pkg::PAD_INDEX_W-1:0] pad_index;
   logic [tpsp_pkg::RAW_COUNT_W-1:0] raw_count;

   modport source (output valid, output pad_index, output raw_count, input ready);
   modport sink   (input valid, input pad_index, input raw_count, output ready);
endinterface

interface tpsp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpsp_pkg::POSITION_W-1:0]      position;
   logic                                 touched;
   logic signed [tpsp_pkg::LEVEL_W-1:0]  touch_level;

   modport source (output valid, output position, output touched, output touch_level,
                   input ready);
   modport sink   (input valid, input position, input touched, input touch_level,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/tpsp_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tpsp_divider
// Unsigned restoring divider, two quotient bits per cycle through a shift
// register; quotient is valid in the cycle done pulses and holds until the
// next start.
// ----------------------------------------------------------------------------
module tpsp_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  tpsp_pkg::tpsp_div_req_type  div_req,
   output tpsp_pkg::tpsp_div_rsp_type  div_rsp
);
   import tpsp_pkg::*;

   logic [DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_SHIFT_W-1:0] shift_ff, shift_in;
   logic [DIV_COUNT_W-1:0] count_ff, count_in;
   logic                   done_ff, done_in;

   logic [DIVISOR_W:0] r1_try, r1_sub, r2_try, r2_sub;
   logic [DIVISOR_W-1:0] r1;
   logic               b1, b2;

   always_comb begin
      r1_try = {rem_ff, shift_ff[DIV_SHIFT_W-1]};
      r1_sub = r1_try - {1'b0, dsr_ff};
      b1     = r1_try >= {1'b0, dsr_ff};
      r1     = b1 ? r1_sub[DIVISOR_W-1:0] : r1_try[DIVISOR_W-1:0];
      r2_try = {r1, shift_ff[DIV_SHIFT_W-2]};
      r2_sub = r2_try - {1'b0, dsr_ff};
      b2     = r2_try >= {1'b0, dsr_ff};

      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = '0;
         dsr_in   = div_req.divisor;
         shift_in = DIV_SHIFT_W'(div_req.dividend);
         count_in = DIV_COUNT_W'(DIV_STEPS);
      end else if (count_ff != '0) begin
         rem_in   = b2 ? r2_sub[DIVISOR_W-1:0] : r2_try[DIVISOR_W-1:0];
         shift_in = {shift_ff[DIV_SHIFT_W-3:0], b1, b2};
         count_in = count_ff - 1'b1;
         done_in  = count_ff == DIV_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      shift_ff <= shift_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = shift_ff[DIVIDEND_W-1:0];

endmodule
`default_nettype wire

@@ rtl/three_pad_slider_position_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_pad_slider_position_top
// Three-pad capacitive slider: offset and clamp per pad, ordering-case
// interpolation with a serial divide, touch detection with hysteresis.
// ----------------------------------------------------------------------------
// Path from accept: a divided position runs CLAMP, XYZ, CASE, DIV, FIN, OUT;
// with no ordering case or a zero divisor, CASE goes to OUT; pad index three
// runs XYZ, OUT. Beats are taken only in IDLE, so none overlaps in the
// two-bit-per-cycle divider. A finished result waits in the output register.
// Reset (synchronous): offsets, scale and shift take their defaults; pad
// values, position, average and touch flag clear to zero.
module three_pad_slider_position_top (
   input  wire                              clock,
   input  wire                              reset,
   tpsp_req_if.sink                         req_if,
   tpsp_rsp_if.source                       rsp_if,
   input  wire                              csr_we,
   input  wire [tpsp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [tpsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tpsp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLAMP = 3'd1;
   localparam logic [2:0] ST_XYZ   = 3'd2;
   localparam logic [2:0] ST_CASE  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [PAD_INDEX_W-1:0]   pad_ff, pad_in;
   logic [RAW_COUNT_W-1:0]   raw_ff, raw_in;

   logic [RAW_COUNT_W-1:0]   offset_ff [3];
   logic [SCALE_W-1:0]       scale_ff;
   logic [SHIFT_W-1:0]       shift_ff;

   logic signed [LEVEL_W-1:0] pad_value_ff [3];
   logic signed [LEVEL_W-1:0] pad_value_in [3];
   logic [POSITION_W-1:0]     held_ff, held_in;
   logic signed [LEVEL_W-1:0] avg_ff, avg_in;
   logic                      touch_ff, touch_in;

   logic signed [LEVEL_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic [13:0]               base_ff, base_in;
   logic                      neg_ff, neg_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POSITION_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                      rsp_touch_ff, rsp_touch_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   tpsp_div_req_type div_req;
   tpsp_div_rsp_type div_rsp;

   tpsp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   function automatic logic signed [LEVEL_W-1:0] half_sum(
      input logic signed [LEVEL_W-1:0] a,
      input logic signed [LEVEL_W-1:0] b
   );
      logic signed [LEVEL_W:0] s;
      logic signed [LEVEL_W:0] t;
      s = {a[LEVEL_W-1], a} + {b[LEVEL_W-1], b};
      t = s + $signed({{LEVEL_W{1'b0}}, s[LEVEL_W]});
      t = t >>> 1;
      return t[LEVEL_W-1:0];
   endfunction

   function automatic logic signed [LEVEL_W-1:0] diff12(
      input logic signed [LEVEL_W-1:0] a,
      input logic signed [LEVEL_W-1:0] b
   );
      logic signed [LEVEL_W:0] d;
      d = {a[LEVEL_W-1], a} - {b[LEVEL_W-1], b};
      return d[LEVEL_W-1:0];
   endfunction

   // clamp path
   logic signed [16:0] raw_diff, raw_dbl, raw_clamp;

   always_comb begin
      raw_diff = $signed({3'b000, raw_ff}) - $signed({3'b000, offset_ff[pad_ff]});
      raw_dbl  = (pad_ff == PAD_2) ? (raw_diff <<< 1) : raw_diff;
      if (raw_dbl < 17'(LEVEL_MIN)) begin
         raw_clamp = 17'(LEVEL_MIN);
      end else if (raw_dbl > 17'sd0) begin
         raw_clamp = '0;
      end else begin
         raw_clamp = raw_dbl;
      end
   end

   // case decode
   logic                      hit, case_neg, go;
   logic signed [LEVEL_W-1:0] num, da, db;
   logic signed [LEVEL_W:0]   den;
   logic [3:0]                seg;
   logic [LEVEL_W-2:0]        num_mag;
   logic [DIVISOR_W-1:0]      den_mag;
   logic [DIVIDEND_W-1:0]     prod;

   always_comb begin
      hit      = 1'b1;
      case_neg = 1'b0;
      num      = z_ff;
      da       = y_ff;
      db       = z_ff;
      seg      = 4'd2;
      if (x_ff < y_ff && x_ff < z_ff && y_ff < z_ff) begin
         num = z_ff; da = y_ff; db = z_ff; seg = 4'd2; case_neg = 1'b1;
      end else if (x_ff < y_ff && x_ff < z_ff && y_ff > z_ff) begin
         num = y_ff; da = y_ff; db = z_ff; seg = 4'd1;
      end else if (z_ff < y_ff && z_ff < x_ff && x_ff < y_ff) begin
         num = y_ff; da = y_ff; db = x_ff; seg = 4'd5; case_neg = 1'b1;
      end else if (z_ff < y_ff && z_ff < x_ff && x_ff > y_ff) begin
         num = x_ff; da = y_ff; db = x_ff; seg = 4'd4;
      end else if (y_ff < x_ff && y_ff < z_ff && z_ff < x_ff) begin
         num = x_ff; da = x_ff; db = z_ff; seg = 4'd8; case_neg = 1'b1;
      end else if (y_ff < x_ff && y_ff < z_ff && z_ff > x_ff) begin
         num = z_ff; da = x_ff; db = z_ff; seg = 4'd7;
      end else begin
         hit = 1'b0;
      end
      den     = {da[LEVEL_W-1], da} + {db[LEVEL_W-1], db};
      go      = hit && (den != '0);
      num_mag = num[LEVEL_W-1] ? 11'(-num) : num[LEVEL_W-2:0];
      den_mag = den[LEVEL_W] ? 12'(-den) : den[DIVISOR_W-1:0];
      prod    = {10'b0, num_mag} * {11'b0, scale_ff};
   end

   always_comb begin
      div_req.start    = (state_ff == ST_CASE) && go;
      div_req.dividend = prod;
      div_req.divisor  = den_mag;
   end

   // touch detection and average
   logic signed [LEVEL_W:0]   delta, avg_diff, avg_step;
   logic [LEVEL_W:0]          avg_mag, avg_shr;

   always_comb begin
      delta    = {avg_ff[LEVEL_W-1], avg_ff} - {level_ff[LEVEL_W-1], level_ff};
      avg_diff = {level_ff[LEVEL_W-1], level_ff} - {avg_ff[LEVEL_W-1], avg_ff};
      avg_mag  = avg_diff[LEVEL_W] ? 13'(-avg_diff) : avg_diff;
      avg_shr  = avg_mag >> shift_ff;
      avg_step = avg_diff[LEVEL_W] ? -$signed(avg_shr) : $signed(avg_shr);
   end

   // final placement
   logic signed [23:0] place;
   logic [POSITION_W-1:0] place_sat;

   always_comb begin
      if (neg_ff) begin
         place = $signed({10'b0, base_ff}) - $signed({3'b0, div_rsp.quotient});
      end else begin
         place = $signed({10'b0, base_ff}) + $signed({3'b0, div_rsp.quotient});
      end
      if (place < 24'sd0) begin
         place_sat = '0;
      end else if (place > $signed({11'b0, POSITION_MAX})) begin
         place_sat = POSITION_MAX;
      end else begin
         place_sat = place[POSITION_W-1:0];
      end
   end

   logic rsp_load;

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      raw_in       = raw_ff;
      pad_value_in = pad_value_ff;
      held_in      = held_ff;
      avg_in       = avg_ff;
      touch_in     = touch_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      level_in     = level_ff;
      base_in      = base_ff;
      neg_in       = neg_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               pad_in   = req_if.pad_index;
               raw_in   = req_if.raw_count;
               state_in = (req_if.pad_index == PAD_NONE) ? ST_XYZ : ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            pad_value_in[pad_ff] = raw_clamp[LEVEL_W-1:0];
            state_in = ST_XYZ;
         end
         ST_XYZ: begin
            x_in = diff12(half_sum(pad_value_ff[0], pad_value_ff[1]), pad_value_ff[2]);
            y_in = diff12(half_sum(pad_value_ff[0], pad_value_ff[2]), pad_value_ff[1]);
            z_in = diff12(half_sum(pad_value_ff[1], pad_value_ff[2]), pad_value_ff[0]);
            level_in = pad_value_ff[0];
            if (pad_value_ff[1] < level_in) begin
               level_in = pad_value_ff[1];
            end
            if (pad_value_ff[2] < level_in) begin
               level_in = pad_value_ff[2];
            end
            state_in = (pad_ff == PAD_NONE) ? ST_OUT : ST_CASE;
         end
         ST_CASE: begin
            if (delta > TOUCH_DOWN_DELTA) begin
               touch_in = 1'b1;
            end else if (delta < TOUCH_UP_DELTA) begin
               touch_in = 1'b0;
            end else if (avg_ff > IDLE_AVERAGE) begin
               touch_in = 1'b0;
            end
            avg_in   = 12'(avg_ff + avg_step);
            base_in  = 14'(scale_ff) * 14'(seg);
            neg_in   = case_neg ^ num[LEVEL_W-1] ^ den[LEVEL_W];
            state_in = go ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            held_in  = place_sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_touch_in = rsp_touch_ff;
      rsp_level_in = rsp_level_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = held_ff;
         rsp_touch_in = touch_ff;
         rsp_level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pad_value_ff[0] <= '0;
         pad_value_ff[1] <= '0;
         pad_value_ff[2] <= '0;
         held_ff         <= '0;
         avg_ff          <= '0;
         touch_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_value_ff <= pad_value_in;
         held_ff      <= held_in;
         avg_ff       <= avg_in;
         touch_ff     <= touch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff       <= pad_in;
      raw_ff       <= raw_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      level_ff     <= level_in;
      base_ff      <= base_in;
      neg_ff       <= neg_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_touch_ff <= rsp_touch_in;
      rsp_level_ff <= rsp_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[0] <= OFFSET_PAD0_RESET;
         offset_ff[1] <= OFFSET_PAD1_RESET;
         offset_ff[2] <= OFFSET_PAD2_RESET;
         scale_ff     <= POSITION_SCALE_RESET;
         shift_ff     <= AVERAGE_SHIFT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_PAD0:    offset_ff[0] <= csr_wdata;
            CSR_OFFSET_PAD1:    offset_ff[1] <= csr_wdata;
            CSR_OFFSET_PAD2:    offset_ff[2] <= csr_wdata;
            CSR_POSITION_SCALE: scale_ff     <= csr_wdata[SCALE_W-1:0];
            CSR_AVERAGE_SHIFT:  shift_ff     <= csr_wdata[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready       = state_ff == ST_IDLE;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.position    = rsp_pos_ff;
   assign rsp_if.touched     = rsp_touch_ff;
   assign rsp_if.touch_level = rsp_level_ff;

endmodule
`default_nettype wire
